>>> src/bnbc_pkg.sv
`timescale 1ns / 1ps
package bnbc_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam int FRAC_W = 16;
    localparam int FRAC_IDX_W = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic        row_label;
        logic [31:0] feature_bits;
    } in_beat_t;

    typedef struct packed {
        logic is_question;
        logic counts_saturated;
    } out_beat_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic inc_q;
        logic inc_o;
    } cell_ctl_t;

    typedef logic [FRAC_W-1:0] frac_tab_t [256];

    // Fraction table built at elaboration by repeated squaring in Q1.31.
    function automatic frac_tab_t build_frac();
        frac_tab_t   t;
        logic [63:0] x;
        logic [15:0] r;
        for (int k = 0; k < 256; k++)
        begin
            x = 64'(256 + k) << 23;
            r = '0;
            for (int b = 15; b >= 0; b--)
            begin
                x = (x * x) >> 31;
                if (x >= 64'h1_0000_0000)
                begin
                    r[b] = 1'b1;
                    x = x >> 1;
                end
            end
            t[k] = r;
        end
        return t;
    endfunction

    localparam frac_tab_t FRAC_TAB = build_frac();

endpackage

>>> src/bnbc_cell.sv
`timescale 1ns / 1ps
module bnbc_cell #(
    parameter int COUNT_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bnbc_pkg::cell_ctl_t   ctl,
    input  logic                  bit_on,
    input  logic [COUNT_BITS-1:0] q_in,
    input  logic [COUNT_BITS-1:0] o_in,
    output logic [COUNT_BITS-1:0] q_on,
    output logic [COUNT_BITS-1:0] o_on
);
    import bnbc_pkg::*;

    logic [COUNT_BITS-1:0] q_reg, q_next;
    logic [COUNT_BITS-1:0] o_reg, o_next;

    always_comb
    begin
        q_next = q_reg;
        o_next = o_reg;
        if (ctl.clear)
        begin
            q_next = '0;
            o_next = '0;
        end
        else if (ctl.shift)
        begin
            q_next = q_in;
            o_next = o_in;
        end
        else
        begin
            if (ctl.inc_q && bit_on)
                q_next = q_reg + 1'b1;
            if (ctl.inc_o && bit_on)
                o_next = o_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
            o_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
            o_reg <= o_next;
        end
    end

    assign q_on = q_reg;
    assign o_on = o_reg;

endmodule

>>> src/bnbc_log.sv
`timescale 1ns / 1ps
module bnbc_log #(
    parameter int IN_W = 13,
    parameter int P_W  = 5
) (
    input  logic [IN_W-1:0]                 v,
    output logic [P_W+bnbc_pkg::FRAC_W-1:0] l
);
    import bnbc_pkg::*;

    logic [P_W-1:0]  p;
    logic [IN_W+7:0] sh;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < IN_W; i++)
            if (v[i])
                p = P_W'(i);
    end

    // The eight bits below the leading one, zero-filled for small values.
    assign sh = {v, 8'b0} >> p;
    assign l  = {p, FRAC_TAB[sh[FRAC_IDX_W-1:0]]};

endmodule

>>> src/binary_naive_bayes_classifier_core.sv
`timescale 1ns / 1ps
// Channel | Ports                                     | Handshake
// input   | cmd (kind, row_label, feature_bits)       | start && !busy
// result  | result (is_question, counts_saturated)    | result_valid, one cycle
// config  | psel penable pwrite paddr pwdata prdata   | APB write, pready tied high
// Busy stays low for clear and training beats.
// A query with both classes trained raises busy while the count cells rotate past
// one shared pair of log units, one feature a cycle. Busy is high until the result
// strobe. A query lacking a class answers in the next cycle.
// Reset clears all counts at once. The receiver cannot stall results.
module binary_naive_bayes_classifier_core #(
    parameter int NUM_FEATURES = 32,
    parameter int COUNT_BITS   = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bnbc_pkg::in_beat_t  cmd,
    output logic                result_valid,
    output bnbc_pkg::out_beat_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bnbc_pkg::*;

    localparam int LIN_W = COUNT_BITS + 1;
    localparam int P_W   = $clog2(LIN_W);
    localparam int LOG_W = P_W + FRAC_W;
    localparam int CNT_W = $clog2(NUM_FEATURES + 3);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_FEATURES + 2);

    logic [5:0]                  fiu_reg;
    logic [7:0]                  used;
    logic [COUNT_BITS-1:0]       rq_reg, ro_reg;
    logic                        sat_reg;
    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [NUM_FEATURES-1:0]     fb_reg;
    logic [LOG_W-1:0]            lq_reg, lo_reg;
    logic signed [31:0]          dd_reg, acc_reg, acc_next, term;
    logic                        rv_reg, isq_reg;
    logic                        acc_in, tr_acc, do_inc;
    cell_ctl_t                   ctl;
    logic [COUNT_BITS-1:0]       q_on [NUM_FEATURES];
    logic [COUNT_BITS-1:0]       o_on [NUM_FEATURES];
    logic [NUM_FEATURES-1:0]     bit_on;
    logic [LIN_W-1:0]            vq, vo;
    logic [LOG_W-1:0]            lq, lo;
    logic [7:0]                  term_idx;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {26'd0, fiu_reg};
    assign used   = (fiu_reg > 6'(NUM_FEATURES > 63 ? 63 : NUM_FEATURES)) &&
                    (NUM_FEATURES < 63) ? 8'(NUM_FEATURES) : {2'b0, fiu_reg};

    assign acc_in = start && !busy_reg;
    assign tr_acc = acc_in && cmd.kind == KIND_TRAIN;
    assign do_inc = tr_acc && ((cmd.row_label ? rq_reg : ro_reg) < COUNT_MAX);

    assign ctl.clear = acc_in && cmd.kind == KIND_CLEAR;
    assign ctl.shift = busy_reg && cnt_reg >= CNT_W'(2) && cnt_reg < LAST_STEP;
    assign ctl.inc_q = do_inc && cmd.row_label;
    assign ctl.inc_o = do_inc && !cmd.row_label;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_FEATURES; gi++)
        begin : g_cell
            if (gi < 32)
            begin : g_b
                assign bit_on[gi] = cmd.feature_bits[gi] && (8'(gi) < used);
            end
            else
            begin : g_z
                assign bit_on[gi] = 1'b0;
            end
            bnbc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .bit_on (bit_on[gi]),
                .q_in   (q_on[(gi + 1) % NUM_FEATURES]),
                .o_in   (o_on[(gi + 1) % NUM_FEATURES]),
                .q_on   (q_on[gi]),
                .o_on   (o_on[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            vq = LIN_W'(rq_reg);
            vo = LIN_W'(ro_reg);
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            vq = LIN_W'(rq_reg) + LIN_W'(4);
            vo = LIN_W'(ro_reg) + LIN_W'(4);
        end
        else if (fb_reg[0])
        begin
            vq = LIN_W'(q_on[0]) + LIN_W'(2);
            vo = LIN_W'(o_on[0]) + LIN_W'(2);
        end
        else
        begin
            vq = LIN_W'(rq_reg - q_on[0]) + LIN_W'(2);
            vo = LIN_W'(ro_reg - o_on[0]) + LIN_W'(2);
        end
    end

    bnbc_log #(.IN_W(LIN_W), .P_W(P_W)) u_log_q (.v(vq), .l(lq));
    bnbc_log #(.IN_W(LIN_W), .P_W(P_W)) u_log_o (.v(vo), .l(lo));

    // Feature terms use the registered logs lq_reg and lo_reg; the first lands at step 3.
    assign term_idx = 8'(cnt_reg) - 8'd3;
    assign term = $signed(32'(lq_reg)) - $signed(32'(lo_reg)) - dd_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (cnt_reg == CNT_W'(1))
            acc_next = $signed(32'(lq_reg)) - $signed(32'(lo_reg));
        else if (cnt_reg >= CNT_W'(3) && term_idx < used)
            acc_next = acc_reg + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg  <= 6'd32;
            rq_reg   <= '0;
            ro_reg   <= '0;
            sat_reg  <= 1'b0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && !paddr[2])
                fiu_reg <= pwdata[5:0];
            rv_reg <= (acc_in && cmd.kind == KIND_QUERY && (rq_reg == '0 || ro_reg == '0))
                      || (busy_reg && cnt_reg == LAST_STEP);
            if (ctl.clear)
            begin
                rq_reg  <= '0;
                ro_reg  <= '0;
                sat_reg <= 1'b0;
            end
            if (tr_acc && !do_inc)
                sat_reg <= 1'b1;
            if (ctl.inc_q)
                rq_reg <= rq_reg + 1'b1;
            if (ctl.inc_o)
                ro_reg <= ro_reg + 1'b1;
            if (acc_in && cmd.kind == KIND_QUERY)
            begin
                if (rq_reg != '0 && ro_reg != '0)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lq_reg  <= lq;
        lo_reg  <= lo;
        acc_reg <= acc_next;
        if (cnt_reg == CNT_W'(2))
            dd_reg <= $signed(32'(lq_reg)) - $signed(32'(lo_reg));
        if (acc_in)
            fb_reg <= NUM_FEATURES'(cmd.feature_bits);
        else if (ctl.shift)
            fb_reg <= fb_reg >> 1;
        if (acc_in && cmd.kind == KIND_QUERY)
            isq_reg <= !(rq_reg == '0 && ro_reg != '0);
        else if (busy_reg && cnt_reg == LAST_STEP)
            isq_reg <= !acc_next[31];
    end

    assign busy                    = busy_reg;
    assign result_valid            = rv_reg;
    assign result.is_question      = isq_reg;
    assign result.counts_saturated = sat_reg;

endmodule

>>> src/bnbc_checker.sv
`timescale 1ns / 1ps
module bnbc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input bnbc_pkg::in_beat_t cmd,
    input logic               result_valid,
    input logic               pready
);
    import bnbc_pkg::*;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy) else $error("result strobe while busy");

    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid) else $error("query ended without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind != KIND_QUERY) |=> !result_valid)
        else $error("result for a beat that is not a query");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");

endmodule

bind binary_naive_bayes_classifier_core bnbc_checker u_bnbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .pready       (pready)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import bnbc_pkg::*;

    localparam int NF        = 32;
    localparam int CNT_MAX   = 4095;
    localparam int SETTLE    = 60;
    localparam int MAX_CYC   = 2000000;
    localparam logic [2:0] ADDR_FEATURES = 3'd0;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        in_beat_t  beat;
        logic      typed;
        out_beat_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_beat_t    cmd;
    logic        result_valid;
    out_beat_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binary_naive_bayes_classifier_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state.
    logic [15:0] log_frac [256];
    logic [5:0]  feat_reg;
    int          q_rows;
    int          o_rows;
    int          q_on [NF];
    int          o_on [NF];
    logic        sat_seen;

    out_beat_t   pending_class [$];
    int          mismatches;
    int          cycles;
    bit          idle_en;
    dir_row_t    dir_tab [20];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_class.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %b", result);
            end
            else
            begin
                if (result !== pending_class[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %b, got %b",
                                 pending_class[0], result);
                end
                void'(pending_class.pop_front());
            end
        end
    end

    function automatic longint fx_log2(int unsigned v);
        int unsigned p;
        int unsigned f;
        p = 0;
        while (p < 31 && (v >> (p + 1)) != 0)
            p++;
        if (p >= 8)
            f = (v >> (p - 8)) & 255;
        else
            f = (v << (8 - p)) & 255;
        return longint'(p) * 65536 + longint'(log_frac[f]);
    endfunction

    function automatic longint class_log_score(int rows, bit is_q, logic [31:0] bits,
                                               int m, longint log_all);
        longint s;
        longint den;
        int     num;
        int     on;
        s = fx_log2(rows) - log_all;
        den = fx_log2(rows + 4);
        for (int i = 0; i < m; i++)
        begin
            on = is_q ? q_on[i] : o_on[i];
            num = bits[i] ? on + 2 : rows - on + 2;
            s += fx_log2(num) - den;
        end
        return s;
    endfunction

    function automatic void wipe_counts();
        q_rows = 0;
        o_rows = 0;
        for (int i = 0; i < NF; i++)
        begin
            q_on[i] = 0;
            o_on[i] = 0;
        end
        sat_seen = 1'b0;
    endfunction

    // Updates the model for one accepted beat and returns whether a result follows.
    function automatic bit classify_beat(in_beat_t b, output out_beat_t r);
        int     m;
        longint lt;
        longint sq;
        longint so;
        m = (feat_reg > NF) ? NF : feat_reg;
        r = '0;
        case (b.kind)
            KIND_CLEAR:
            begin
                wipe_counts();
                return 0;
            end
            KIND_TRAIN:
            begin
                if ((b.row_label ? q_rows : o_rows) >= CNT_MAX)
                    sat_seen = 1'b1;
                else
                begin
                    if (b.row_label)
                        q_rows++;
                    else
                        o_rows++;
                    for (int i = 0; i < m; i++)
                        if (b.feature_bits[i])
                        begin
                            if (b.row_label)
                                q_on[i]++;
                            else
                                o_on[i]++;
                        end
                end
                return 0;
            end
            KIND_QUERY:
            begin
                if (q_rows == 0 && o_rows == 0)
                    r.is_question = 1'b1;
                else if (q_rows == 0)
                    r.is_question = 1'b0;
                else if (o_rows == 0)
                    r.is_question = 1'b1;
                else
                begin
                    lt = fx_log2(q_rows + o_rows);
                    sq = class_log_score(q_rows, 1'b1, b.feature_bits, m, lt);
                    so = class_log_score(o_rows, 1'b0, b.feature_bits, m, lt);
                    r.is_question = (so > sq) ? 1'b0 : 1'b1;
                end
                r.counts_saturated = sat_seen;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic rest_inputs(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Start stays high across back-to-back beats; idling and register writes lower it.
    task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
        out_beat_t r;
        bit        has_res;
        if (idle_en && $urandom_range(0, 3) == 0)
            rest_inputs($urandom_range(1, 13));
        start <= 1'b1;
        cmd <= b;
        do
            @(posedge clk);
        while (busy);
        has_res = classify_beat(b, r);
        if (has_res)
            pending_class.push_back(typed ? want : r);
    endtask

    task automatic write_features(logic [5:0] val);
        start <= 1'b0;
        while (pending_class.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_FEATURES;
        pwdata <= {26'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        feat_reg = val;
    endtask

    function automatic in_beat_t random_beat();
        in_beat_t    b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        b.kind = (pick < 2) ? KIND_CLEAR : (pick < 4) ? KIND_NONE :
                 (pick < 60) ? KIND_TRAIN : KIND_QUERY;
        b.row_label = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: b.feature_bits = '0;
            1: b.feature_bits = '1;
            default: b.feature_bits = $urandom;
        endcase
        return b;
    endfunction

    initial
    begin
        logic [63:0] x;
        logic [5:0]  phase_cfg [8];
        in_beat_t    b;

        for (int k = 0; k < 256; k++)
        begin
            x = 64'(256 + k) << 23;
            log_frac[k] = '0;
            for (int j = 15; j >= 0; j--)
            begin
                x = (x * x) >> 31;
                if (x >= 64'h1_0000_0000)
                begin
                    log_frac[k][j] = 1'b1;
                    x = x >> 1;
                end
            end
        end

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        mismatches = 0;
        idle_en = 1'b1;
        feat_reg = 6'd32;
        wipe_counts();

        dir_tab[0]  = '{'{KIND_QUERY, 1'b0, 32'h0}, 1'b1, 2'b10};
        dir_tab[1]  = '{'{KIND_TRAIN, 1'b0, 32'h0}, 1'b0, 2'b00};
        dir_tab[2]  = '{'{KIND_QUERY, 1'b1, 32'hFFFF_FFFF}, 1'b1, 2'b00};
        dir_tab[3]  = '{'{KIND_CLEAR, 1'b0, 32'h0}, 1'b0, 2'b00};
        dir_tab[4]  = '{'{KIND_TRAIN, 1'b1, 32'hFFFF_FFFF}, 1'b0, 2'b00};
        dir_tab[5]  = '{'{KIND_QUERY, 1'b0, 32'h0}, 1'b1, 2'b10};
        dir_tab[6]  = '{'{KIND_TRAIN, 1'b0, 32'h0}, 1'b0, 2'b00};
        dir_tab[7]  = '{'{KIND_QUERY, 1'b0, 32'hFFFF_FFFF}, 1'b0, 2'b00};
        dir_tab[8]  = '{'{KIND_QUERY, 1'b0, 32'h0}, 1'b0, 2'b00};
        dir_tab[9]  = '{'{KIND_NONE, 1'b1, 32'hFFFF_FFFF}, 1'b0, 2'b00};
        dir_tab[10] = '{'{KIND_TRAIN, 1'b1, 32'h0}, 1'b0, 2'b00};
        dir_tab[11] = '{'{KIND_TRAIN, 1'b0, 32'hFFFF_FFFF}, 1'b0, 2'b00};
        dir_tab[12] = '{'{KIND_QUERY, 1'b0, 32'h8000_0001}, 1'b0, 2'b00};
        dir_tab[13] = '{'{KIND_QUERY, 1'b0, 32'h5555_5555}, 1'b0, 2'b00};
        dir_tab[14] = '{'{KIND_QUERY, 1'b0, 32'hAAAA_AAAA}, 1'b0, 2'b00};
        // Identical training for both classes must tie, and a tie picks question.
        dir_tab[15] = '{'{KIND_CLEAR, 1'b0, 32'h0}, 1'b0, 2'b00};
        dir_tab[16] = '{'{KIND_TRAIN, 1'b1, 32'h0F0F_0F0F}, 1'b0, 2'b00};
        dir_tab[17] = '{'{KIND_TRAIN, 1'b0, 32'h0F0F_0F0F}, 1'b0, 2'b00};
        dir_tab[18] = '{'{KIND_QUERY, 1'b0, 32'h1234_5678}, 1'b1, 2'b10};
        dir_tab[19] = '{'{KIND_QUERY, 1'b1, 32'hFFFF_FFFF}, 1'b1, 2'b10};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 20; i++)
            send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

        // Register settings include the extremes and values outside the legal range.
        phase_cfg = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd17, 6'd33, 6'd5, 6'd32};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_features(phase_cfg[ph]);
            for (int i = 0; i < 110; i++)
            begin
                if (ph == 7)
                    idle_en = 1'b0;
                else if (i % 40 == 0)
                    idle_en = $urandom_range(0, 2) != 0;
                b = random_beat();
                send_beat(b, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_class.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
